// ===== src/chm_pkg.sv =====
// Shared types and constants of the monotone chain convex hull block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package chm_pkg;

  // width of the coordinate fields on the channels
  localparam int unsigned PT_W = 12;

  // datapath operations, one per controller state
  typedef enum logic [4:0] {
    OP_LOAD,
    OP_SORT_INIT,
    OP_SORT_RD,
    OP_SORT_LD,
    OP_SORT_CMP,
    OP_SORT_WR,
    OP_DED_INIT,
    OP_DED_RD,
    OP_DED_PR,
    OP_CH_INIT,
    OP_CH_RD,
    OP_CH_LD,
    OP_CH_SIDE,
    OP_UP_CHK,
    OP_UP_WAIT,
    OP_UP_POP,
    OP_UP_RLD,
    OP_UP_PUSH,
    OP_LO_CHK,
    OP_LO_WAIT,
    OP_LO_POP,
    OP_LO_RLD,
    OP_LO_PUSH,
    OP_NEXT,
    OP_EM_FIRST,
    OP_EM_FIRST_OUT,
    OP_EM_RD,
    OP_EM_OUT,
    OP_NO_EDGE
  } chm_op_e;

  // datapath status towards the controller
  typedef struct packed {
    logic last_acc;   // beat carrying the last point taken
    logic sort_end;   // insertion sort walked all points
    logic gt;         // fetched point above the one being inserted
    logic j_one;      // insertion slot about to reach the bottom
    logic ded_end;    // duplicate removal at its final point
    logic few;        // fewer than two distinct points
    logic ori_done;   // orientation result ready
    logic ori_neg;    // clockwise
    logic ori_pos;    // counter-clockwise
    logic want_up;    // current point joins the upper chain
    logic want_lo;    // current point joins the lower chain
    logic un_ge2;     // upper chain holds two or more points
    logic ln_ge2;     // lower chain holds two or more points
    logic last_i;     // current point is the rightmost one
    logic out_free;   // output register can take a beat
    logic k_last;     // final hull edge
  } chm_sts_t;

endpackage

`default_nettype wire

// ===== src/chm_point_if.sv =====
// Point input channel: valid/ready handshake with one point per beat.
// Depends on chm_pkg for the coordinate width.
`default_nettype none

interface chm_point_if;
  logic                      valid;
  logic                      ready;
  logic [chm_pkg::PT_W-1:0]  point_x;
  logic [chm_pkg::PT_W-1:0]  point_y;
  logic                      last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

// ===== src/chm_edge_if.sv =====
// Hull edge output channel: valid/ready handshake with one edge per beat.
// Depends on chm_pkg for the coordinate width.
`default_nettype none

interface chm_edge_if;
  logic                      valid;
  logic                      ready;
  logic [chm_pkg::PT_W-1:0]  start_x;
  logic [chm_pkg::PT_W-1:0]  start_y;
  logic [chm_pkg::PT_W-1:0]  end_x;
  logic [chm_pkg::PT_W-1:0]  end_y;
  logic                      no_edge;
  logic                      overflow;
  logic                      last_edge;

  modport source (output valid, start_x, start_y, end_x, end_y, no_edge, overflow,
                  last_edge, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, no_edge, overflow,
                  last_edge, output ready);
endinterface

`default_nettype wire

// ===== src/convex_hull_monotone_chain.sv =====
// Top level of the monotone chain convex hull block.
// Depends on chm_pkg, chm_point_if, chm_edge_if, chm_ctrl and chm_datapath.
//
//   channel   dir  beat
//   point_i   in   one point (x, y, last flag)
//   edge_o    out  one hull edge (start, end, flags)
//
// Points are taken one a cycle while loading. After the last point the block
// sorts the store by insertion, removes duplicates, builds both chains (bound
// by the orientation unit) and sends the hull edges.
// Reset is asynchronous, active low, and leaves the block loading.
// Stalls on edge_o hold the sequencer; point_i is not taken during a run.
`default_nettype none

module convex_hull_monotone_chain #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  chm_point_if.sink    point_i,
  chm_edge_if.source   edge_o
);

  chm_pkg::chm_op_e   cmd;
  chm_pkg::chm_sts_t  sts;

  chm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  chm_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .point_i (point_i),
    .edge_o  (edge_o)
  );

endmodule

`default_nettype wire

// ===== src/chm_datapath.sv =====
// Datapath of the hull block: point store, chain stores, counters,
// orientation unit and output register. Depends on chm_pkg and both interfaces.
`default_nettype none

module chm_datapath #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  chm_pkg::chm_op_e    cmd_i,
  output chm_pkg::chm_sts_t   sts_o,
  chm_point_if.sink           point_i,
  chm_edge_if.source          edge_o
);

  localparam int unsigned CW  = (COORD_BITS < chm_pkg::PT_W) ? COORD_BITS : chm_pkg::PT_W;
  localparam int unsigned PW  = 2 * CW;
  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned NW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned HW  = NW + 1;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PRW = 2 * DW;

  // stores
  logic [PW-1:0] pts_mem [MAX_POINTS];
  logic [PW-1:0] up_mem  [MAX_POINTS];
  logic [PW-1:0] lo_mem  [MAX_POINTS];
  logic [PW-1:0] rd_q, urd_q, lrd_q;

  // counters and working registers
  logic [NW-1:0] cnt_q, i_q, j_q, n_q, un_q, ln_q;
  logic [HW-1:0] k_q;
  logic          ovf_q;
  logic [PW-1:0] v_q, last_q, p0_q, cur_q, prev_q;
  logic [PW-1:0] ut1_q, ut2_q, lt1_q, lt2_q;
  logic          want_up_q, want_lo_q, sel_up_q;

  // orientation unit
  logic [PW-1:0]          oa_q, ob_q, oc_q;
  logic                   s0_q, s1_q, s2_q;
  logic signed [PRW-1:0]  p1_q, p2_q;
  logic                   neg_q, pos_q;

  // output register
  logic                      ov_q;
  logic [chm_pkg::PT_W-1:0]  sx_q, sy_q, ex_q, ey_q;
  logic                      ne_q, of_q, le_q;

  // combinational
  logic          acc, gt, new_pt, out_free, k_last, last_i;
  logic [NW-1:0] im1, jm2, unm3, lnm3;
  logic [HW-1:0] h, hidx, lidx;
  logic          hup;
  logic [PW-1:0] sel_pt;
  logic          pw_en;
  logic [AW-1:0] pw_addr, pr_addr, ur_addr, lr_addr;
  logic [PW-1:0] pw_data;
  logic          ori_go;
  logic [PW-1:0] ga, gb, gc;
  logic signed [DW-1:0]  dx1, dy1, dx2, dy2;
  logic signed [PRW-1:0] df;

  assign acc      = (cmd_i == chm_pkg::OP_LOAD) && point_i.valid;
  assign point_i.ready = (cmd_i == chm_pkg::OP_LOAD);
  assign gt       = rd_q > v_q;
  assign new_pt   = (n_q == '0) || (rd_q != last_q);
  assign out_free = !ov_q || edge_o.ready;
  assign im1      = i_q - NW'(1);
  assign jm2      = j_q - NW'(2);
  assign unm3     = un_q - NW'(3);
  assign lnm3     = ln_q - NW'(3);
  assign last_i   = (i_q == n_q - NW'(1));

  // hull walk: upper chain forwards, then lower chain backwards
  assign h      = HW'(un_q) + HW'(ln_q) - HW'(2);
  assign hidx   = (cmd_i == chm_pkg::OP_EM_FIRST || cmd_i == chm_pkg::OP_EM_FIRST_OUT)
                  ? h - HW'(1) : k_q;
  assign hup    = hidx < HW'(un_q);
  assign lidx   = h - hidx;
  assign sel_pt = sel_up_q ? urd_q : lrd_q;
  assign k_last = (k_q == h - HW'(1));

  // point store write and read port selection
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = j_q[AW-1:0];
    pw_data = rd_q;
    pr_addr = i_q[AW-1:0];
    case (cmd_i)
      chm_pkg::OP_LOAD: begin
        pw_en   = acc && (cnt_q < NW'(MAX_POINTS));
        pw_addr = cnt_q[AW-1:0];
        pw_data = {point_i.point_x[CW-1:0], point_i.point_y[CW-1:0]};
      end
      chm_pkg::OP_SORT_LD: begin
        pr_addr = im1[AW-1:0];
      end
      chm_pkg::OP_SORT_CMP: begin
        pw_en   = gt;
        pr_addr = jm2[AW-1:0];
      end
      chm_pkg::OP_SORT_WR: begin
        pw_en   = 1'b1;
        pw_data = v_q;
      end
      chm_pkg::OP_DED_PR: begin
        pw_en   = new_pt;
        pw_addr = n_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // chain store read addresses
  assign ur_addr = (cmd_i == chm_pkg::OP_UP_POP) ? unm3[AW-1:0] : hidx[AW-1:0];
  assign lr_addr = (cmd_i == chm_pkg::OP_LO_POP) ? lnm3[AW-1:0] : lidx[AW-1:0];

  // point store
  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      pts_mem[pw_addr] <= pw_data;
    end
    rd_q <= pts_mem[pr_addr];
  end

  // chain stores
  always_ff @(posedge clk_i) begin
    if (cmd_i == chm_pkg::OP_CH_INIT) begin
      up_mem[0] <= p0_q;
      lo_mem[0] <= p0_q;
    end
    if (cmd_i == chm_pkg::OP_UP_PUSH) begin
      up_mem[un_q[AW-1:0]] <= cur_q;
    end
    if (cmd_i == chm_pkg::OP_LO_PUSH) begin
      lo_mem[ln_q[AW-1:0]] <= cur_q;
    end
    urd_q    <= up_mem[ur_addr];
    lrd_q    <= lo_mem[lr_addr];
    sel_up_q <= hup;
  end

  // orientation operand selection
  always_comb begin
    ori_go = 1'b0;
    ga     = p0_q;
    gb     = rd_q;
    gc     = last_q;
    case (cmd_i)
      chm_pkg::OP_CH_LD: begin
        ori_go = 1'b1;
      end
      chm_pkg::OP_UP_CHK: begin
        ori_go = want_up_q && (un_q >= NW'(2));
        ga     = ut2_q;
        gb     = ut1_q;
        gc     = cur_q;
      end
      chm_pkg::OP_LO_CHK: begin
        ori_go = want_lo_q && (ln_q >= NW'(2));
        ga     = lt2_q;
        gb     = lt1_q;
        gc     = cur_q;
      end
      default: begin
      end
    endcase
  end

  // cross product (b-a) x (c-a), two products then one subtract
  assign dx1 = $signed({1'b0, ob_q[PW-1:CW]}) - $signed({1'b0, oa_q[PW-1:CW]});
  assign dy1 = $signed({1'b0, ob_q[CW-1:0]})  - $signed({1'b0, oa_q[CW-1:0]});
  assign dx2 = $signed({1'b0, oc_q[PW-1:CW]}) - $signed({1'b0, oa_q[PW-1:CW]});
  assign dy2 = $signed({1'b0, oc_q[CW-1:0]})  - $signed({1'b0, oa_q[CW-1:0]});
  assign df  = p1_q - p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= 1'b0;
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s0_q <= ori_go;
      s1_q <= s0_q;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ori_go) begin
      oa_q <= ga;
      ob_q <= gb;
      oc_q <= gc;
    end
    p1_q <= dx1 * dy2;
    p2_q <= dy1 * dx2;
    if (s1_q) begin
      neg_q <= df[PRW-1];
      pos_q <= !df[PRW-1] && (df != '0);
    end
  end

  // counters, chain lengths and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      n_q   <= '0;
      un_q  <= '0;
      ln_q  <= '0;
      k_q   <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (edge_o.ready) begin
        ov_q <= 1'b0;
      end
      case (cmd_i)
        chm_pkg::OP_LOAD: begin
          if (acc) begin
            if (cnt_q < NW'(MAX_POINTS)) begin
              cnt_q <= cnt_q + NW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        chm_pkg::OP_SORT_INIT: i_q <= NW'(1);
        chm_pkg::OP_SORT_LD:   j_q <= i_q;
        chm_pkg::OP_SORT_CMP: begin
          if (gt) begin
            j_q <= j_q - NW'(1);
          end
        end
        chm_pkg::OP_SORT_WR: i_q <= i_q + NW'(1);
        chm_pkg::OP_DED_INIT: begin
          i_q <= '0;
          n_q <= '0;
        end
        chm_pkg::OP_DED_PR: begin
          i_q <= i_q + NW'(1);
          if (new_pt) begin
            n_q <= n_q + NW'(1);
          end
        end
        chm_pkg::OP_CH_INIT: begin
          un_q <= NW'(1);
          ln_q <= NW'(1);
          i_q  <= NW'(1);
        end
        chm_pkg::OP_UP_POP:  un_q <= un_q - NW'(1);
        chm_pkg::OP_UP_PUSH: un_q <= un_q + NW'(1);
        chm_pkg::OP_LO_POP:  ln_q <= ln_q - NW'(1);
        chm_pkg::OP_LO_PUSH: ln_q <= ln_q + NW'(1);
        chm_pkg::OP_NEXT:    i_q  <= i_q + NW'(1);
        chm_pkg::OP_EM_FIRST_OUT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            k_q  <= HW'(1);
          end
        end
        chm_pkg::OP_EM_OUT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            k_q  <= k_q + HW'(1);
            if (k_last) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        chm_pkg::OP_NO_EDGE: begin
          if (out_free) begin
            ov_q  <= 1'b1;
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      chm_pkg::OP_SORT_LD: v_q <= rd_q;
      chm_pkg::OP_DED_PR: begin
        if (new_pt) begin
          last_q <= rd_q;
          if (n_q == '0) begin
            p0_q <= rd_q;
          end
        end
      end
      chm_pkg::OP_CH_INIT: begin
        ut1_q <= p0_q;
        lt1_q <= p0_q;
      end
      chm_pkg::OP_CH_LD: cur_q <= rd_q;
      chm_pkg::OP_CH_SIDE: begin
        if (s2_q) begin
          want_up_q <= last_i || neg_q;
          want_lo_q <= last_i || pos_q;
        end
      end
      chm_pkg::OP_UP_POP:  ut1_q <= ut2_q;
      chm_pkg::OP_UP_RLD:  ut2_q <= urd_q;
      chm_pkg::OP_UP_PUSH: begin
        ut2_q <= ut1_q;
        ut1_q <= cur_q;
      end
      chm_pkg::OP_LO_POP:  lt1_q <= lt2_q;
      chm_pkg::OP_LO_RLD:  lt2_q <= lrd_q;
      chm_pkg::OP_LO_PUSH: begin
        lt2_q <= lt1_q;
        lt1_q <= cur_q;
      end
      chm_pkg::OP_EM_FIRST_OUT: begin
        if (out_free) begin
          prev_q <= p0_q;
          sx_q   <= chm_pkg::PT_W'(p0_q[PW-1:CW]);
          sy_q   <= chm_pkg::PT_W'(p0_q[CW-1:0]);
          ex_q   <= chm_pkg::PT_W'(sel_pt[PW-1:CW]);
          ey_q   <= chm_pkg::PT_W'(sel_pt[CW-1:0]);
          ne_q   <= 1'b0;
          of_q   <= ovf_q;
          le_q   <= 1'b0;
        end
      end
      chm_pkg::OP_EM_OUT: begin
        if (out_free) begin
          prev_q <= sel_pt;
          sx_q   <= chm_pkg::PT_W'(prev_q[PW-1:CW]);
          sy_q   <= chm_pkg::PT_W'(prev_q[CW-1:0]);
          ex_q   <= chm_pkg::PT_W'(sel_pt[PW-1:CW]);
          ey_q   <= chm_pkg::PT_W'(sel_pt[CW-1:0]);
          ne_q   <= 1'b0;
          of_q   <= ovf_q;
          le_q   <= k_last;
        end
      end
      chm_pkg::OP_NO_EDGE: begin
        if (out_free) begin
          sx_q <= '0;
          sy_q <= '0;
          ex_q <= '0;
          ey_q <= '0;
          ne_q <= 1'b1;
          of_q <= ovf_q;
          le_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign edge_o.valid     = ov_q;
  assign edge_o.start_x   = sx_q;
  assign edge_o.start_y   = sy_q;
  assign edge_o.end_x     = ex_q;
  assign edge_o.end_y     = ey_q;
  assign edge_o.no_edge   = ne_q;
  assign edge_o.overflow  = of_q;
  assign edge_o.last_edge = le_q;

  // status
  assign sts_o.last_acc = acc && point_i.last_point;
  assign sts_o.sort_end = i_q >= cnt_q;
  assign sts_o.gt       = gt;
  assign sts_o.j_one    = (j_q == NW'(1));
  assign sts_o.ded_end  = (i_q == cnt_q - NW'(1));
  assign sts_o.few      = n_q < NW'(2);
  assign sts_o.ori_done = s2_q;
  assign sts_o.ori_neg  = neg_q;
  assign sts_o.ori_pos  = pos_q;
  assign sts_o.want_up  = want_up_q;
  assign sts_o.want_lo  = want_lo_q;
  assign sts_o.un_ge2   = un_q >= NW'(2);
  assign sts_o.ln_ge2   = ln_q >= NW'(2);
  assign sts_o.last_i   = last_i;
  assign sts_o.out_free = out_free;
  assign sts_o.k_last   = k_last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MAX_POINTS))
    else $error("point count above capacity");

  a_noedge_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_o.valid && edge_o.no_edge |-> edge_o.last_edge)
    else $error("empty result not marked last");

  a_chain_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == chm_pkg::OP_UP_CHK) |-> (un_q != '0) && (un_q <= n_q))
    else $error("upper chain length out of range");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == chm_pkg::OP_EM_OUT) && out_free && k_last |=> (cnt_q == '0) && !ovf_q)
    else $error("run state not cleared after final edge");
`endif

endmodule

`default_nettype wire

// ===== src/chm_ctrl.sv =====
// Controller of the hull block: sequences load, sort, dedup, chain build
// and edge output. Depends on chm_pkg.
`default_nettype none

module chm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  chm_pkg::chm_sts_t   sts_i,
  output chm_pkg::chm_op_e    cmd_o
);

  typedef enum logic [4:0] {
    S_LOAD, S_SORT_INIT, S_SORT_RD, S_SORT_LD, S_SORT_CMP, S_SORT_WR,
    S_DED_INIT, S_DED_RD, S_DED_PR,
    S_CH_INIT, S_CH_RD, S_CH_LD, S_CH_SIDE,
    S_UP_CHK, S_UP_WAIT, S_UP_POP, S_UP_RLD, S_UP_PUSH,
    S_LO_CHK, S_LO_WAIT, S_LO_POP, S_LO_RLD, S_LO_PUSH,
    S_NEXT, S_EM_FIRST, S_EM_FIRST_OUT, S_EM_RD, S_EM_OUT, S_NO_EDGE
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:      if (sts_i.last_acc) state_d = S_SORT_INIT;
      S_SORT_INIT: state_d = S_SORT_RD;
      S_SORT_RD:   state_d = sts_i.sort_end ? S_DED_INIT : S_SORT_LD;
      S_SORT_LD:   state_d = S_SORT_CMP;
      S_SORT_CMP:  if (!(sts_i.gt && !sts_i.j_one)) state_d = S_SORT_WR;
      S_SORT_WR:   state_d = S_SORT_RD;
      S_DED_INIT:  state_d = S_DED_RD;
      S_DED_RD:    state_d = S_DED_PR;
      S_DED_PR:    state_d = sts_i.ded_end ? S_CH_INIT : S_DED_RD;
      S_CH_INIT:   state_d = sts_i.few ? S_NO_EDGE : S_CH_RD;
      S_CH_RD:     state_d = S_CH_LD;
      S_CH_LD:     state_d = S_CH_SIDE;
      S_CH_SIDE:   if (sts_i.ori_done) state_d = S_UP_CHK;
      S_UP_CHK: begin
        if (!sts_i.want_up)     state_d = S_LO_CHK;
        else if (!sts_i.un_ge2) state_d = S_UP_PUSH;
        else                    state_d = S_UP_WAIT;
      end
      S_UP_WAIT:   if (sts_i.ori_done) state_d = sts_i.ori_neg ? S_UP_PUSH : S_UP_POP;
      S_UP_POP:    state_d = S_UP_RLD;
      S_UP_RLD:    state_d = S_UP_CHK;
      S_UP_PUSH:   state_d = S_LO_CHK;
      S_LO_CHK: begin
        if (!sts_i.want_lo)     state_d = S_NEXT;
        else if (!sts_i.ln_ge2) state_d = S_LO_PUSH;
        else                    state_d = S_LO_WAIT;
      end
      S_LO_WAIT:   if (sts_i.ori_done) state_d = sts_i.ori_pos ? S_LO_PUSH : S_LO_POP;
      S_LO_POP:    state_d = S_LO_RLD;
      S_LO_RLD:    state_d = S_LO_CHK;
      S_LO_PUSH:   state_d = S_NEXT;
      S_NEXT:      state_d = sts_i.last_i ? S_EM_FIRST : S_CH_RD;
      S_EM_FIRST:  state_d = S_EM_FIRST_OUT;
      S_EM_FIRST_OUT: if (sts_i.out_free) state_d = S_EM_RD;
      S_EM_RD:     state_d = S_EM_OUT;
      S_EM_OUT:    if (sts_i.out_free) state_d = sts_i.k_last ? S_LOAD : S_EM_RD;
      S_NO_EDGE:   if (sts_i.out_free) state_d = S_LOAD;
      default:     state_d = S_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  always_comb begin
    case (state_q)
      S_LOAD:         cmd_o = chm_pkg::OP_LOAD;
      S_SORT_INIT:    cmd_o = chm_pkg::OP_SORT_INIT;
      S_SORT_RD:      cmd_o = chm_pkg::OP_SORT_RD;
      S_SORT_LD:      cmd_o = chm_pkg::OP_SORT_LD;
      S_SORT_CMP:     cmd_o = chm_pkg::OP_SORT_CMP;
      S_SORT_WR:      cmd_o = chm_pkg::OP_SORT_WR;
      S_DED_INIT:     cmd_o = chm_pkg::OP_DED_INIT;
      S_DED_RD:       cmd_o = chm_pkg::OP_DED_RD;
      S_DED_PR:       cmd_o = chm_pkg::OP_DED_PR;
      S_CH_INIT:      cmd_o = chm_pkg::OP_CH_INIT;
      S_CH_RD:        cmd_o = chm_pkg::OP_CH_RD;
      S_CH_LD:        cmd_o = chm_pkg::OP_CH_LD;
      S_CH_SIDE:      cmd_o = chm_pkg::OP_CH_SIDE;
      S_UP_CHK:       cmd_o = chm_pkg::OP_UP_CHK;
      S_UP_WAIT:      cmd_o = chm_pkg::OP_UP_WAIT;
      S_UP_POP:       cmd_o = chm_pkg::OP_UP_POP;
      S_UP_RLD:       cmd_o = chm_pkg::OP_UP_RLD;
      S_UP_PUSH:      cmd_o = chm_pkg::OP_UP_PUSH;
      S_LO_CHK:       cmd_o = chm_pkg::OP_LO_CHK;
      S_LO_WAIT:      cmd_o = chm_pkg::OP_LO_WAIT;
      S_LO_POP:       cmd_o = chm_pkg::OP_LO_POP;
      S_LO_RLD:       cmd_o = chm_pkg::OP_LO_RLD;
      S_LO_PUSH:      cmd_o = chm_pkg::OP_LO_PUSH;
      S_NEXT:         cmd_o = chm_pkg::OP_NEXT;
      S_EM_FIRST:     cmd_o = chm_pkg::OP_EM_FIRST;
      S_EM_FIRST_OUT: cmd_o = chm_pkg::OP_EM_FIRST_OUT;
      S_EM_RD:        cmd_o = chm_pkg::OP_EM_RD;
      S_EM_OUT:       cmd_o = chm_pkg::OP_EM_OUT;
      S_NO_EDGE:      cmd_o = chm_pkg::OP_NO_EDGE;
      default:        cmd_o = chm_pkg::OP_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_convex_hull_monotone_chain.sv =====
// Self-checking testbench of the monotone chain convex hull block.
// Depends on chm_pkg, chm_point_if, chm_edge_if and convex_hull_monotone_chain.
`timescale 1ns / 1ps

module tb_convex_hull_monotone_chain;

  localparam int unsigned NPTS      = 64;
  localparam int unsigned CYC_LIMIT = 2000000;
  localparam int unsigned HOLD_CYC  = 600;

  typedef logic [chm_pkg::PT_W-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   no_edge;
    logic   ovf;
    logic   last;
  } hull_seg_t;

  logic clk_i;
  logic rst_ni;

  chm_point_if pt_if ();
  chm_edge_if  seg_if ();

  convex_hull_monotone_chain u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (pt_if),
    .edge_o  (seg_if)
  );

  // expected hull edges, oldest first
  hull_seg_t   hull_seg_q[$];
  // points of the set being loaded, packed as x << 16 | y
  logic [31:0] set_pts[NPTS];
  int unsigned set_cnt;
  logic        set_ovf;

  int unsigned n_err;
  int unsigned n_sent;
  int unsigned n_cyc;
  bit          quiet;       // no random idling on either side
  int unsigned hold_req;    // receiver hold-off requests from the tests
  int unsigned hold_seen;   // requests already served by the receiver
  int unsigned hold_cnt;

  // clock and cycle limit
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc > CYC_LIMIT) begin
      $display("tb_convex_hull_monotone_chain failed");
      $finish;
    end
  end

  // signed orientation of three packed points
  function automatic longint orient(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    longint ax, ay, bx, by, cx, cy;
    ax = a[27:16]; ay = a[11:0];
    bx = b[27:16]; by = b[11:0];
    cx = c[27:16]; cy = c[11:0];
    return ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
  endfunction

  function automatic hull_seg_t mk_seg(logic [31:0] a, logic [31:0] b, logic ovf,
                                       logic last);
    hull_seg_t s;
    s.sx = a[27:16]; s.sy = a[11:0];
    s.ex = b[27:16]; s.ey = b[11:0];
    s.no_edge = 1'b0;
    s.ovf = ovf;
    s.last = last;
    return s;
  endfunction

  // closes the set: sort, dedup, both chains, queue the hull edges
  task automatic hull_expect();
    logic [31:0] p[NPTS];
    int          up[NPTS];
    int          lo[NPTS];
    int          hl[NPTS];
    logic [31:0] v;
    hull_seg_t   s;
    int          n, j, un, ln, h;
    for (int i = 0; i < int'(set_cnt); i++) p[i] = set_pts[i];
    for (int i = 1; i < int'(set_cnt); i++) begin
      v = p[i];
      j = i;
      while (j > 0 && p[j-1] > v) begin
        p[j] = p[j-1];
        j--;
      end
      p[j] = v;
    end
    n = 0;
    for (int i = 0; i < int'(set_cnt); i++)
      if (n == 0 || p[n-1] != p[i]) begin
        p[n] = p[i];
        n++;
      end
    if (n < 2) begin
      s = '{sx: '0, sy: '0, ex: '0, ey: '0, no_edge: 1'b1, ovf: set_ovf, last: 1'b1};
      hull_seg_q.insert(hull_seg_q.size(), s);
    end else begin
      up[0] = 0; lo[0] = 0; un = 1; ln = 1;
      for (int i = 1; i < n; i++) begin
        if (i == n - 1 || orient(p[0], p[i], p[n-1]) < 0) begin
          while (un >= 2 && !(orient(p[up[un-2]], p[up[un-1]], p[i]) < 0)) un--;
          if (un < NPTS) begin up[un] = i; un++; end
        end
        if (i == n - 1 || orient(p[0], p[i], p[n-1]) > 0) begin
          while (ln >= 2 && !(orient(p[lo[ln-2]], p[lo[ln-1]], p[i]) > 0)) ln--;
          if (ln < NPTS) begin lo[ln] = i; ln++; end
        end
      end
      h = 0;
      for (int i = 0; i < un && h < NPTS; i++) begin hl[h] = up[i]; h++; end
      for (int i = ln - 2; i > 0 && h < NPTS; i--) begin hl[h] = lo[i]; h++; end
      hull_seg_q.insert(hull_seg_q.size(), mk_seg(p[hl[0]], p[hl[h-1]], set_ovf, h == 1));
      for (int k = 0; k + 1 < h; k++)
        hull_seg_q.insert(hull_seg_q.size(),
                          mk_seg(p[hl[k]], p[hl[k+1]], set_ovf, k + 2 == h));
    end
    set_cnt = 0;
    set_ovf = 1'b0;
  endtask

  // one point beat, with random idle cycles ahead of it
  task automatic send_point(coord_t x, coord_t y, logic last);
    while (!quiet && $urandom_range(99) < 26) begin
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_if.valid      <= 1'b1;
    pt_if.point_x    <= x;
    pt_if.point_y    <= y;
    pt_if.last_point <= last;
    do @(posedge clk_i); while (!pt_if.ready);
    n_sent++;
    if (set_cnt < NPTS) begin
      set_pts[set_cnt] = {4'd0, x, 4'd0, y};
      set_cnt++;
    end else begin
      set_ovf = 1'b1;
    end
    if (last) hull_expect();
  endtask

  task automatic send_set(int unsigned cnt, coord_t lo_c, coord_t hi_c);
    for (int unsigned i = 0; i < cnt; i++)
      send_point(coord_t'($urandom_range(hi_c, lo_c)),
                 coord_t'($urandom_range(hi_c, lo_c)), i == cnt - 1);
  endtask

  task automatic wait_drain();
    pt_if.valid <= 1'b0;
    while (hull_seg_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_seen    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_cnt     <= HOLD_CYC;
      hold_seen    <= hold_req;
      seg_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      seg_if.ready <= 1'b0;
    end else begin
      seg_if.ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  // result check against the oldest expected edge
  always @(posedge clk_i) begin
    hull_seg_t e;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      if (hull_seg_q.size() == 0) begin
        $error("unexpected hull edge beat");
        n_err++;
      end else begin
        e = hull_seg_q.pop_front();
        if (seg_if.no_edge !== e.no_edge) begin
          $error("no_edge: expected %0d, got %0d", e.no_edge, seg_if.no_edge); n_err++;
        end
        if (seg_if.overflow !== e.ovf) begin
          $error("overflow: expected %0d, got %0d", e.ovf, seg_if.overflow); n_err++;
        end
        if (seg_if.last_edge !== e.last) begin
          $error("last_edge: expected %0d, got %0d", e.last, seg_if.last_edge); n_err++;
        end
        // an empty result carries zero edge fields
        if (seg_if.start_x !== e.sx) begin
          $error("start_x: expected %0d, got %0d", e.sx, seg_if.start_x); n_err++;
        end
        if (seg_if.start_y !== e.sy) begin
          $error("start_y: expected %0d, got %0d", e.sy, seg_if.start_y); n_err++;
        end
        if (seg_if.end_x !== e.ex) begin
          $error("end_x: expected %0d, got %0d", e.ex, seg_if.end_x); n_err++;
        end
        if (seg_if.end_y !== e.ey) begin
          $error("end_y: expected %0d, got %0d", e.ey, seg_if.end_y); n_err++;
        end
      end
    end
  end

  // directed: degenerate sets
  task automatic test_degenerate();
    send_point(12'd0, 12'd0, 1'b1);                 // single point
    send_point(12'd4095, 12'd4095, 1'b0);           // only repeats
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b1);
    send_point(12'd4095, 12'd4095, 1'b0);           // two points, extremes
    send_point(12'd0, 12'd0, 1'b1);
    send_point(12'd0, 12'd4095, 1'b0);              // vertical collinear
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd0, 12'd2048, 1'b1);
    send_point(12'd100, 12'd100, 1'b0);             // diagonal collinear
    send_point(12'd300, 12'd300, 1'b0);
    send_point(12'd200, 12'd200, 1'b1);
  endtask

  // directed: square with interior, edge and repeated points
  task automatic test_square();
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd2047, 12'd2047, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b0);
    send_point(12'd2048, 12'd0, 1'b0);
    send_point(12'd0, 12'd4095, 1'b0);
    send_point(12'd4095, 12'd0, 1'b0);
    send_point(12'd1365, 12'd2730, 1'b1);
  endtask

  // store full: the dropped last point still closes the set
  task automatic test_overflow();
    send_set(NPTS + 2, 12'd0, 12'd4095);
    send_set(3, 12'd0, 12'd15);                     // flag clears after a run
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_req++;
    send_set(10, 12'd0, 12'd4095);
    send_set(8, 12'd0, 12'd4095);
    send_set(5, 12'd0, 12'd4095);
  endtask

  // sender waits until every expected edge has arrived
  task automatic test_drain_pause();
    send_set(6, 12'd0, 12'd4095);
    wait_drain();
    send_set(6, 12'd0, 12'd4095);
  endtask

  // sets back to back with no idling on either side
  task automatic test_no_idle();
    quiet = 1'b1;
    for (int i = 0; i < 4; i++) send_set($urandom_range(12, 2), 12'd0, 12'd4095);
    quiet = 1'b0;
  endtask

  // random sets: mostly small, some in a tight box for repeats and collinear runs
  task automatic test_random();
    int unsigned cnt;
    coord_t      base;
    while (n_sent < 300) begin
      cnt = ($urandom_range(19) == 0) ? $urandom_range(NPTS, 20) : $urandom_range(12, 1);
      if ($urandom_range(2) == 0) begin
        base = coord_t'($urandom_range(4090));
        send_set(cnt, base, base + 12'd4);
      end else begin
        send_set(cnt, 12'd0, 12'd4095);
      end
    end
  endtask

  initial begin
    n_sent = 0;
    quiet = 1'b0; hold_req = 0;
    set_cnt = 0; set_ovf = 1'b0;
    pt_if.valid      = 1'b0;
    pt_if.point_x    = '0;
    pt_if.point_y    = '0;
    pt_if.last_point = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate();
    test_square();
    test_overflow();
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    test_random();

    wait_drain();
    repeat (100) @(posedge clk_i);
    if (n_err == 0 && hull_seg_q.size() == 0) begin
      $display("tb_convex_hull_monotone_chain passed");
    end else begin
      $display("tb_convex_hull_monotone_chain failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/chm_pkg.sv
src/chm_point_if.sv
src/chm_edge_if.sv
src/chm_datapath.sv
src/chm_ctrl.sv
src/convex_hull_monotone_chain.sv
tb/tb_convex_hull_monotone_chain.sv
